>>> rtl/itl_pkg.sv
// ----------------------------------------------------------------------------
// itl_pkg: shared types and constants for the interval table lookup
// Field widths, parameter defaults, item codes and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package itl_pkg;

  localparam int TIME_W   = 48;
  localparam int CODE_W   = 16;
  localparam int ID_W     = 32;
  localparam int SEQ_W    = 12;
  localparam int IDX_IN_W = 12;
  localparam int CNT_IN_W = 13;

  localparam int DEF_MAX_ENTRIES = 4096;
  localparam int DEF_SCAN_SPAN   = 10;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]        start;
    logic [TIME_W-1:0]        stop;
    logic signed [CODE_W-1:0] code;
    logic [ID_W-1:0]          id;
    logic [SEQ_W-1:0]         seq;
  } entry_t;

  typedef struct packed {
    logic ld_wr;      // write the incoming entry into the table
    logic q_load;     // capture a query and open the full range
    logic bis_rd;     // read the midpoint of the range
    logic bis_upd;    // narrow the range from the midpoint compare
    logic scan_init;  // start the forward scan at the low bound
    logic scan_rd;    // read the entry under the scan pointer
    logic scan_adv;   // step the scan pointer
    logic run_set;    // the scan has entered the overlapping run
    logic res_wr;     // load the result register
    logic res_hit;    // result is a hit on the entry just read
  } ctl_cmd_t;

  typedef struct packed {
    logic span_big;   // range still wider than the scan span
    logic bis_stall;  // bisection step would not shrink the range
    logic k_end;      // scan pointer reached the entry count
    logic past;       // query time is after the entry's stop
    logic early;      // query time is before the entry's start
    logic code_eq;    // entry code equals the wanted code
    logic run;        // scan is inside the overlapping run
    logic out_busy;   // result register full and not being taken
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/itl_in_if.sv
// ----------------------------------------------------------------------------
// itl_in_if: input item channel
// Valid/ready channel carrying one load or query item.
// ----------------------------------------------------------------------------
`default_nettype none

interface itl_in_if
  import itl_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [IDX_IN_W-1:0]        entry_index;
  logic [TIME_W-1:0]          start_time;
  logic [TIME_W-1:0]          stop_time;
  logic signed [CODE_W-1:0]   code;
  logic [ID_W-1:0]            entry_id;
  logic [SEQ_W-1:0]           entry_seq;
  logic [TIME_W-1:0]          query_time;

  modport source (
    output valid, action, entry_index, start_time, stop_time, code, entry_id,
           entry_seq, query_time,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, start_time, stop_time, code, entry_id,
           entry_seq, query_time,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/itl_out_if.sv
// ----------------------------------------------------------------------------
// itl_out_if: result item channel
// Valid/ready channel carrying one lookup result.
// ----------------------------------------------------------------------------
`default_nettype none

interface itl_out_if
  import itl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             found;
  logic [ID_W-1:0]  match_id;
  logic [SEQ_W-1:0] match_seq;

  modport source (
    output valid, found, match_id, match_seq,
    input  ready
  );
  modport sink (
    input  valid, found, match_id, match_seq,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/itl_ctl.sv
// ----------------------------------------------------------------------------
// itl_ctl: lookup controller
// Sequences table loads, the bisection on stop times and the forward scan,
// and decides hit or miss from the datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module itl_ctl
  import itl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_action,
  output logic          in_ready,
  input  wire dp_sts_t  sts,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_BIS_CHK   = 3'd1;
  localparam logic [2:0] ST_BIS_EVAL  = 3'd2;
  localparam logic [2:0] ST_SCAN_CHK  = 3'd3;
  localparam logic [2:0] ST_SCAN_EVAL = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       fin;
  logic       fin_hit;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    fin       = 1'b0;
    fin_hit   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACT_QUERY) begin
            cmd.q_load = 1'b1;
            state_nxt  = ST_BIS_CHK;
          end else begin
            cmd.ld_wr = 1'b1;
          end
        end
      end
      ST_BIS_CHK: begin
        if (sts.span_big) begin
          cmd.bis_rd = 1'b1;
          state_nxt  = ST_BIS_EVAL;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN_CHK;
        end
      end
      ST_BIS_EVAL: begin
        if (sts.bis_stall) begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN_CHK;
        end else begin
          cmd.bis_upd = 1'b1;
          state_nxt   = ST_BIS_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (sts.k_end) begin
          fin = 1'b1;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_EVAL;
        end
      end
      ST_SCAN_EVAL: begin
        // Inside the run an ended entry closes the search; before the run
        // it is skipped, and an entry that starts too late is a miss.
        priority if (sts.past && sts.run) begin
          fin = 1'b1;
        end else if (sts.past) begin
          cmd.scan_adv = 1'b1;
          state_nxt    = ST_SCAN_CHK;
        end else if (!sts.run && sts.early) begin
          fin = 1'b1;
        end else if (sts.code_eq) begin
          fin     = 1'b1;
          fin_hit = 1'b1;
        end else begin
          cmd.scan_adv = 1'b1;
          cmd.run_set  = 1'b1;
          state_nxt    = ST_SCAN_CHK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A finished query waits here, its read data held, until the result
    // register can take it.
    if (fin && !sts.out_busy) begin
      cmd.res_wr  = 1'b1;
      cmd.res_hit = fin_hit;
      state_nxt   = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ld_wr, cmd.q_load, cmd.bis_rd, cmd.bis_upd, cmd.scan_init,
              cmd.scan_rd, cmd.scan_adv, cmd.res_wr}))
    else $error("more than one datapath command in a cycle");

  a_no_stall_upd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bis_upd |-> !sts.bis_stall)
    else $error("range update issued on a stalled bisection step");

  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_wr |=> in_ready)
    else $error("controller not ready after delivering a result");

endmodule

`default_nettype wire

>>> rtl/itl_dp.sv
// ----------------------------------------------------------------------------
// itl_dp: lookup datapath
// Entry table memory with one registered read port, the search range and
// scan registers, the time and code comparators and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module itl_dp
  import itl_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int SCAN_SPAN   = DEF_SCAN_SPAN
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CNT_IN_W-1:0]      cfg_wdata,
  input  wire logic [IDX_IN_W-1:0]      in_entry_index,
  input  wire logic [TIME_W-1:0]        in_start_time,
  input  wire logic [TIME_W-1:0]        in_stop_time,
  input  wire logic signed [CODE_W-1:0] in_code,
  input  wire logic [ID_W-1:0]          in_entry_id,
  input  wire logic [SEQ_W-1:0]         in_entry_seq,
  input  wire logic [TIME_W-1:0]        in_query_time,
  input  wire ctl_cmd_t                 cmd,
  output dp_sts_t                       sts,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_found,
  output logic [ID_W-1:0]               out_match_id,
  output logic [SEQ_W-1:0]              out_match_seq
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int WW    = ((CW > CNT_IN_W) ? CW : CNT_IN_W) + 1;
  localparam int AW    = (IDX_W > IDX_IN_W) ? IDX_W : IDX_IN_W;

  entry_t                   mem [0:MAX_ENTRIES-1];
  entry_t                   rd_r;
  logic [CNT_IN_W-1:0]      count_r;
  logic [TIME_W-1:0]        t_r;
  logic signed [CODE_W-1:0] want_r;
  logic [CW-1:0]            n_r;
  logic [CW-1:0]            lo_r;
  logic [CW-1:0]            hi_r;
  logic [CW-1:0]            mid_r;
  logic [CW-1:0]            k_r;
  logic                     run_r;
  logic                     out_valid_r;
  logic                     found_r;
  logic [ID_W-1:0]          id_r;
  logic [SEQ_W-1:0]         seq_r;

  entry_t           wr_entry;
  logic [AW-1:0]    slot_w;
  logic             slot_ok;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_en;
  logic [CW-1:0]    n_act;
  logic [CW:0]      sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    span;
  logic [CW-1:0]    mid_inc;
  logic [CW-1:0]    nlo;
  logic [CW-1:0]    nhi;
  logic             past;

  assign wr_entry = '{start: in_start_time, stop: in_stop_time, code: in_code,
                      id: in_entry_id, seq: in_entry_seq};
  assign slot_w   = AW'(in_entry_index);
  assign slot_ok  = WW'(in_entry_index) < WW'(MAX_ENTRIES);
  assign wr_addr  = slot_w[IDX_W-1:0];

  // A count above the table depth searches the whole table.
  assign n_act = (WW'(count_r) > WW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_r);

  assign sum     = (CW+1)'(lo_r) + (CW+1)'(hi_r);
  assign mid     = sum[CW:1];
  assign span    = hi_r - lo_r;
  assign mid_inc = mid_r + CW'(1);
  assign past    = t_r > rd_r.stop;
  assign nlo     = past ? mid_r : lo_r;
  assign nhi     = past ? hi_r : ((mid_inc < n_r) ? mid_inc : n_r);

  assign rd_en   = cmd.bis_rd || cmd.scan_rd;
  assign rd_addr = cmd.bis_rd ? mid[IDX_W-1:0] : k_r[IDX_W-1:0];

  always_comb begin
    sts.span_big  = WW'(span) > WW'(SCAN_SPAN);
    sts.bis_stall = (nlo == lo_r) && (nhi == hi_r);
    sts.k_end     = k_r >= n_r;
    sts.past      = past;
    sts.early     = t_r < rd_r.start;
    sts.code_eq   = rd_r.code == want_r;
    sts.run       = run_r;
    sts.out_busy  = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_wr && slot_ok) begin
      mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      t_r    <= in_query_time;
      want_r <= in_code;
      n_r    <= n_act;
      lo_r   <= '0;
      hi_r   <= n_act;
    end
    if (cmd.bis_rd) begin
      mid_r <= mid;
    end
    if (cmd.bis_upd) begin
      lo_r <= nlo;
      hi_r <= nhi;
    end
    if (cmd.scan_init) begin
      k_r   <= lo_r;
      run_r <= 1'b0;
    end
    if (cmd.scan_adv) begin
      k_r <= k_r + CW'(1);
      if (cmd.run_set) begin
        run_r <= 1'b1;
      end
    end
    if (cmd.res_wr) begin
      found_r <= cmd.res_hit;
      id_r    <= cmd.res_hit ? rd_r.id : '0;
      seq_r   <= cmd.res_hit ? rd_r.seq : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (cmd.res_wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_match_id  = id_r;
  assign out_match_seq = seq_r;

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bis_upd |-> (nlo < nhi) && (nhi <= n_r))
    else $error("bisection range out of order");

  a_range_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bis_upd |=> (CW'(hi_r - lo_r) < $past(span)))
    else $error("bisection step did not shrink the range");

  a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> (k_r < n_r))
    else $error("scan read beyond the entry count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_wr |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

>>> rtl/interval_table_time_lookup_unit.sv
// Load item: no result; the next item can follow at once.
// Query: B bisection steps (about log2(count/SCAN_SPAN), each a table read and a
// compare) followed by S scanned entries.
// The table reads, one at a time on the single read port, set the query time.
// The next item is accepted the cycle after the query's result enters the output register.
// Reset clears the controller, the entry count and the output valid; table undefined.
// ----------------------------------------------------------------------------
// interval_table_time_lookup_unit: interval table lookup by time and code
// Stores time intervals (the user loads them sorted by start; the block does not sort)
// and answers by bisection on stop times, then a short forward scan for a code match.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_table_time_lookup_unit
  import itl_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int SCAN_SPAN   = DEF_SCAN_SPAN
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [CNT_IN_W-1:0] cfg_wdata,
  itl_in_if.sink                   in_ch,
  itl_out_if.source                out_ch
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     in_ready;

  assign in_ch.ready = in_ready;

  itl_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  itl_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SCAN_SPAN   (SCAN_SPAN)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_entry_index (in_ch.entry_index),
    .in_start_time  (in_ch.start_time),
    .in_stop_time   (in_ch.stop_time),
    .in_code        (in_ch.code),
    .in_entry_id    (in_ch.entry_id),
    .in_entry_seq   (in_ch.entry_seq),
    .in_query_time  (in_ch.query_time),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_found      (out_ch.found),
    .out_match_id   (out_ch.match_id),
    .out_match_seq  (out_ch.match_seq)
  );

endmodule

`default_nettype wire
